/* src/pga_pkg.sv */
// ----------------------------------------------------------------------------
// pga_pkg
// Shared widths, register codes and sideband types for the pairwise gravity
// acceleration pipeline.
// ----------------------------------------------------------------------------
package pga_pkg;

  // Fixed point format of all values
  localparam int FRAC_BITS  = 16;
  localparam int DW         = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_W      = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GRAV_CONST = 1'b0,
    REG_MIN_DIST   = 1'b1
  } cfg_reg_t;

  // Datapath widths
  localparam int MAG_W    = DW + 1;                  // |delta|, below 2^32
  localparam int GM_W     = 2 * DW;                  // G * m
  localparam int SUM_W    = 2 * MAG_W;               // dx^2 + dy^2
  localparam int ROOT_W   = 34;                      // floor(sqrt(sum))
  localparam int SQ_STEPS = ROOT_W;                  // one root bit per stage
  localparam int SQ_W     = 2 * ROOT_W;              // trial value width
  localparam int D2_W     = 2 * ROOT_W;              // d^2
  localparam int DEN_W    = D2_W + ROOT_W;           // d^3
  localparam int NUM_W    = GM_W + MAG_W + FRAC_BITS; // G*m*|delta| << frac
  localparam int QUO_W    = DW;                      // quotient bits kept
  localparam int CMP_W    = DEN_W + QUO_W;           // shifted divisor width
  localparam int PP_W     = DW + MAG_W;              // half-width partial product

  // Sideband that rides along the square root stages
  typedef struct packed {
    logic [MAG_W-1:0] adx;
    logic [MAG_W-1:0] ady;
    logic             xneg;   // result x is negative (dx > 0)
    logic             yneg;
    logic [GM_W-1:0]  gm;
  } side_t;

  // Per-item flags that ride along the divider stages
  typedef struct packed {
    logic neg;
    logic ovf;
    logic zero;
  } div_flag_t;

  // One result item
  typedef struct packed {
    logic signed [DW-1:0] accel_x;
    logic signed [DW-1:0] accel_y;
    logic                 saturated;
  } result_t;

endpackage

/* src/pga_ifs.sv */
// ----------------------------------------------------------------------------
// pga_ifs
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface pga_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   self_x;
  logic signed [31:0]   self_y;
  logic signed [31:0]   other_x;
  logic signed [31:0]   other_y;
  logic        [31:0]   other_mass;

  modport source (output valid, self_x, self_y, other_x, other_y, other_mass,
                  input ready);
  modport sink   (input valid, self_x, self_y, other_x, other_y, other_mass,
                  output ready);
endinterface

interface pga_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   accel_x;
  logic signed [31:0]   accel_y;
  logic                 saturated;

  modport source (output valid, accel_x, accel_y, saturated, input ready);
  modport sink   (input valid, accel_x, accel_y, saturated, output ready);
endinterface

/* src/pairwise_gravity_acceleration_unit.sv */
// A result item passes S0-S2, the square root, P0-P4, the dividers, the final stage and the output buffer.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds only while the two-entry output buffer is full.
// Depth is set by the square root (34 stages) and the divider (32 stages).
// Reset (synchronous, active low) empties the pipeline and the output buffer
// and sets grav_constant and min_distance to 1.0.
// ----------------------------------------------------------------------------
// pairwise_gravity_acceleration_unit
// Softened 2D gravitational acceleration -G*m*delta/d^3 in signed fixed point,
// saturated to 32 bits.
// ----------------------------------------------------------------------------
module pairwise_gravity_acceleration_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  pga_in_if.sink                          in_ch,
  pga_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [pga_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pga_pkg::CFG_W-1:0]       cfg_wdata
);
  import pga_pkg::*;

  localparam logic [DW-1:0] ONE_Q    = DW'(1) << FRAC_BITS;
  localparam logic [DW-1:0] POS_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] NEG_MIN  = {1'b1, {(DW-1){1'b0}}};

  // Saturating map of a quotient to a signed result; bit 0 is the sat flag
  function automatic logic [DW:0] map_comp(input logic [QUO_W-1:0] q,
                                           input div_flag_t f);
    logic [DW:0] r;
    if (f.zero) begin
      r = '0;
    end else if (f.ovf) begin
      r = {(f.neg ? NEG_MIN : POS_MAX), 1'b1};
    end else if (f.neg) begin
      if (q > NEG_MIN) r = {NEG_MIN, 1'b1};
      else             r = {DW'(-q), 1'b0};
    end else begin
      if (q > POS_MAX) r = {POS_MAX, 1'b1};
      else             r = {q, 1'b0};
    end
    return r;
  endfunction

  // Configuration registers
  logic [CFG_W-1:0] grav_r;
  logic [CFG_W-1:0] mind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= ONE_Q;
      mind_r <= ONE_Q;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_GRAV_CONST: grav_r <= cfg_wdata;
        REG_MIN_DIST:   mind_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Global advance: hold while the output buffer is full
  logic en;
  logic buf_full;
  assign en          = !buf_full;
  assign in_ch.ready = en;

  // S0: separations, magnitudes, G*m
  logic signed [MAG_W-1:0] dx, dy;
  logic [MAG_W-1:0] adx_s0_r, ady_s0_r;
  logic             xneg_s0_r, yneg_s0_r, v_s0_r;
  logic [GM_W-1:0]  gm_s0_r;

  assign dx = MAG_W'(in_ch.self_x) - MAG_W'(in_ch.other_x);
  assign dy = MAG_W'(in_ch.self_y) - MAG_W'(in_ch.other_y);

  always_ff @(posedge clk) begin
    if (en) begin
      adx_s0_r  <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      ady_s0_r  <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      xneg_s0_r <= !dx[MAG_W-1] && (dx != '0);
      yneg_s0_r <= !dy[MAG_W-1] && (dy != '0);
      gm_s0_r   <= grav_r * in_ch.other_mass;
    end
  end

  // S1: squares
  logic [SUM_W-1:0] sqx_s1_r, sqy_s1_r;
  side_t            side_s1_r;
  logic             v_s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_s1_r  <= adx_s0_r * adx_s0_r;
      sqy_s1_r  <= ady_s0_r * ady_s0_r;
      side_s1_r <= '{adx: adx_s0_r, ady: ady_s0_r, xneg: xneg_s0_r,
                     yneg: yneg_s0_r, gm: gm_s0_r};
    end
  end

  // S2: squared distance
  logic [SUM_W-1:0] sum_s2_r;
  side_t            side_s2_r;
  logic             v_s2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_s2_r  <= sqx_s1_r + sqy_s1_r;
      side_s2_r <= side_s1_r;
    end
  end

  // Square root pipeline
  logic              sq_v;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  pga_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_s2_r),
    .in_sum    (sum_s2_r),
    .in_side   (side_s2_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // P0: clamp distance, half partial products of the numerators
  logic [ROOT_W-1:0] d_p0_r;
  logic [PP_W-1:0]   pxl_p0_r, pxh_p0_r, pyl_p0_r, pyh_p0_r;
  logic              xneg_p0_r, yneg_p0_r, v_p0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_p0_r    <= (sq_root < ROOT_W'(mind_r)) ? ROOT_W'(mind_r) : sq_root;
      pxl_p0_r  <= sq_side.gm[DW-1:0]    * sq_side.adx;
      pxh_p0_r  <= sq_side.gm[GM_W-1:DW] * sq_side.adx;
      pyl_p0_r  <= sq_side.gm[DW-1:0]    * sq_side.ady;
      pyh_p0_r  <= sq_side.gm[GM_W-1:DW] * sq_side.ady;
      xneg_p0_r <= sq_side.xneg;
      yneg_p0_r <= sq_side.yneg;
    end
  end

  // P1: d^2, full numerators
  logic [D2_W-1:0]   d2_p1_r;
  logic [ROOT_W-1:0] d_p1_r;
  logic [NUM_W-1:0]  numx_p1_r, numy_p1_r;
  logic              xneg_p1_r, yneg_p1_r, zero_p1_r, v_p1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d2_p1_r   <= d_p0_r * d_p0_r;
      d_p1_r    <= d_p0_r;
      numx_p1_r <= ((NUM_W'(pxh_p0_r) << DW) + NUM_W'(pxl_p0_r)) << FRAC_BITS;
      numy_p1_r <= ((NUM_W'(pyh_p0_r) << DW) + NUM_W'(pyl_p0_r)) << FRAC_BITS;
      zero_p1_r <= d_p0_r == '0;
      xneg_p1_r <= xneg_p0_r;
      yneg_p1_r <= yneg_p0_r;
    end
  end

  // P2: d^3 as two partial products
  logic [D2_W-1:0]  d3a_p2_r, d3b_p2_r;
  logic [NUM_W-1:0] numx_p2_r, numy_p2_r;
  logic             xneg_p2_r, yneg_p2_r, zero_p2_r, v_p2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d3a_p2_r  <= d2_p1_r[ROOT_W-1:0]    * d_p1_r;
      d3b_p2_r  <= d2_p1_r[D2_W-1:ROOT_W] * d_p1_r;
      numx_p2_r <= numx_p1_r;
      numy_p2_r <= numy_p1_r;
      zero_p2_r <= zero_p1_r;
      xneg_p2_r <= xneg_p1_r;
      yneg_p2_r <= yneg_p1_r;
    end
  end

  // P3: combine d^3
  logic [DEN_W-1:0] den_p3_r;
  logic [NUM_W-1:0] numx_p3_r, numy_p3_r;
  logic             xneg_p3_r, yneg_p3_r, zero_p3_r, v_p3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      den_p3_r  <= (DEN_W'(d3b_p2_r) << ROOT_W) + DEN_W'(d3a_p2_r);
      numx_p3_r <= numx_p2_r;
      numy_p3_r <= numy_p2_r;
      zero_p3_r <= zero_p2_r;
      xneg_p3_r <= xneg_p2_r;
      yneg_p3_r <= yneg_p2_r;
    end
  end

  // P4: quotient range check
  logic [DEN_W-1:0] den_p4_r;
  logic [NUM_W-1:0] numx_p4_r, numy_p4_r;
  div_flag_t        fx_p4_r, fy_p4_r;
  logic             v_p4_r;
  logic [CMP_W-1:0] den_lim;

  assign den_lim = CMP_W'(den_p3_r) << QUO_W;

  always_ff @(posedge clk) begin
    if (en) begin
      den_p4_r  <= den_p3_r;
      numx_p4_r <= numx_p3_r;
      numy_p4_r <= numy_p3_r;
      fx_p4_r   <= '{neg: xneg_p3_r, ovf: CMP_W'(numx_p3_r) >= den_lim,
                     zero: zero_p3_r};
      fy_p4_r   <= '{neg: yneg_p3_r, ovf: CMP_W'(numy_p3_r) >= den_lim,
                     zero: zero_p3_r};
    end
  end

  // Valid bits of the local stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s0_r <= 1'b0;
      v_s1_r <= 1'b0;
      v_s2_r <= 1'b0;
      v_p0_r <= 1'b0;
      v_p1_r <= 1'b0;
      v_p2_r <= 1'b0;
      v_p3_r <= 1'b0;
      v_p4_r <= 1'b0;
    end else if (en) begin
      v_s0_r <= in_ch.valid;
      v_s1_r <= v_s0_r;
      v_s2_r <= v_s1_r;
      v_p0_r <= sq_v;
      v_p1_r <= v_p0_r;
      v_p2_r <= v_p1_r;
      v_p3_r <= v_p2_r;
      v_p4_r <= v_p3_r;
    end
  end

  // Divider pipelines, one per component
  logic             dvx_v, dvy_v;
  logic [QUO_W-1:0] qx, qy;
  div_flag_t        fx, fy;

  pga_div u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_p4_r),
    .in_num    (numx_p4_r),
    .in_den    (den_p4_r),
    .in_flag   (fx_p4_r),
    .out_valid (dvx_v),
    .out_quo   (qx),
    .out_flag  (fx)
  );

  pga_div u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_p4_r),
    .in_num    (numy_p4_r),
    .in_den    (den_p4_r),
    .in_flag   (fy_p4_r),
    .out_valid (dvy_v),
    .out_quo   (qy),
    .out_flag  (fy)
  );

  // Final stage: sign and saturation
  logic [DW:0] mx, my;
  result_t     res_f_r;
  logic        v_f_r;

  assign mx = map_comp(qx, fx);
  assign my = map_comp(qy, fy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f_r <= 1'b0;
    end else if (en) begin
      v_f_r <= dvx_v && dvy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_f_r <= '{accel_x: mx[DW:1], accel_y: my[DW:1],
                   saturated: mx[0] | my[0]};
    end
  end

  // Output buffer
  result_t out_data;

  pga_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (v_f_r && en),
    .push_data (res_f_r),
    .full      (buf_full),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.accel_x   = out_data.accel_x;
  assign out_ch.accel_y   = out_data.accel_y;
  assign out_ch.saturated = out_data.saturated;

endmodule

/* src/pga_sqrt.sv */
// ----------------------------------------------------------------------------
// pga_sqrt
// Pipelined integer square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module pga_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [pga_pkg::SUM_W-1:0]     in_sum,
  input  pga_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic [pga_pkg::ROOT_W-1:0]    out_root,
  output pga_pkg::side_t                out_side
);
  import pga_pkg::*;

  logic [SQ_STEPS-1:0] vld_r;
  logic [SUM_W-1:0]    rem_r  [SQ_STEPS];
  logic [ROOT_W-1:0]   root_r [SQ_STEPS];
  side_t               side_r [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam int B = SQ_STEPS - 1 - k;

    logic              v_in;
    logic [SUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    side_t             side_in;
    logic [SQ_W-1:0]   trial;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_sum;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign trial = (SQ_W'(root_in) << (B + 1)) + (SQ_W'(1) << (2 * B));
    assign take  = SQ_W'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? SUM_W'(SQ_W'(rem_in) - trial) : rem_in;
        root_r[k] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[SQ_STEPS-1];
  assign out_root  = root_r[SQ_STEPS-1];
  assign out_side  = side_r[SQ_STEPS-1];

endmodule

/* src/pga_div.sv */
// ----------------------------------------------------------------------------
// pga_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees the quotient fits QUO_W bits unless the overflow flag is set.
// ----------------------------------------------------------------------------
module pga_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [pga_pkg::NUM_W-1:0]   in_num,
  input  logic [pga_pkg::DEN_W-1:0]   in_den,
  input  pga_pkg::div_flag_t          in_flag,
  output logic                        out_valid,
  output logic [pga_pkg::QUO_W-1:0]   out_quo,
  output pga_pkg::div_flag_t          out_flag
);
  import pga_pkg::*;

  logic [QUO_W-1:0] vld_r;
  logic [NUM_W-1:0] rem_r  [QUO_W];
  logic [DEN_W-1:0] den_r  [QUO_W];
  logic [QUO_W-1:0] quo_r  [QUO_W];
  div_flag_t        flag_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int B = QUO_W - 1 - k;

    logic             v_in;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    div_flag_t        flag_in;
    logic [CMP_W-1:0] shifted;
    logic             take;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign flag_in = in_flag;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign flag_in = flag_r[k-1];
    end

    // Trial subtract of den * 2^B
    assign shifted = CMP_W'(den_in) << B;
    assign take    = CMP_W'(rem_in) >= shifted;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? NUM_W'(CMP_W'(rem_in) - shifted) : rem_in;
        den_r[k]  <= den_in;
        quo_r[k]  <= take ? (quo_in | (QUO_W'(1) << B)) : quo_in;
        flag_r[k] <= flag_in;
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];
  assign out_flag  = flag_r[QUO_W-1];

endmodule

/* src/pga_obuf.sv */
// ----------------------------------------------------------------------------
// pga_obuf
// Two-entry output buffer between the pipeline and the result channel.
// ----------------------------------------------------------------------------
module pga_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pga_pkg::result_t   push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output pga_pkg::result_t   out_data
);
  import pga_pkg::*;

  result_t     mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;
  logic        pop;

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign full      = cnt_r == 2'd2;
  assign out_valid = cnt_r != 2'd0;
  assign out_data  = mem_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/pga_chk.sv */
// ----------------------------------------------------------------------------
// pga_chk
// Port-level checks of the pairwise gravity acceleration unit.
// ----------------------------------------------------------------------------
module pga_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] accel_x,
  input logic signed [31:0] accel_y,
  input logic               saturated
);

  // Items accepted but not yet delivered
  logic [7:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 8'd0;
    end else begin
      cnt_r <= cnt_r + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
    end
  end

  // A result item is never shown without an accepted item behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 8'd0)
    else $error("result item without a pending input item");

  // Input is held back only while a result item is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // Stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped under stall");

  // Stalled result payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(accel_x) && $stable(accel_y) && $stable(saturated))
    else $error("result payload changed under stall");

endmodule

bind pairwise_gravity_acceleration_unit pga_chk u_pga_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .accel_x   (out_ch.accel_x),
  .accel_y   (out_ch.accel_y),
  .saturated (out_ch.saturated)
);
